/* rtl/core/s1dbh_pkg.sv */
// Shared types, constants and a helper function for the double-width SHA-1 hash.
package s1dbh_pkg;

   localparam int LEN_CNT_BITS = 64;
   localparam int NUM_ENG      = 4;
   localparam int HALF_WORDS   = 5;
   localparam int BLOCK_WORDS  = 16;
   localparam int CHAIN_DEPTH  = NUM_ENG * HALF_WORDS;
   localparam int BLOCK_DEPTH  = NUM_ENG * BLOCK_WORDS;
   localparam int SHA_ROUNDS   = 80;
   localparam int DIGEST_WORDS = 2 * HALF_WORDS;

   localparam logic KIND_BYTE   = 1'b0;
   localparam logic KIND_FINISH = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [3:0]  word_index;
      logic        last_word;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_BRD,
      ST_BWR,
      ST_HLD,
      ST_WLD,
      ST_RUN,
      ST_HADD,
      ST_POST,
      ST_HWB,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      JOB_BYTE,
      JOB_FIN1,
      JOB_FIN2,
      JOB_L2
   } job_type;

   typedef struct packed {
      logic       h_load;
      logic [2:0] h_idx;
      logic       iv_load;
      logic       w_push;
      logic       round_en;
      logic [6:0] round;
      logic       h_add;
   } rnd_ctl_type;

   function automatic logic [31:0] sha_iv(input logic [2:0] idx);
      logic [31:0] v;
      case (idx)
         3'd0: v = 32'h6745_2301;
         3'd1: v = 32'hEFCD_AB89;
         3'd2: v = 32'h98BA_DCFE;
         3'd3: v = 32'h1032_5476;
         3'd4: v = 32'hC3D2_E1F0;
         default: v = 32'h0;
      endcase
      return v;
   endfunction

endpackage

/* rtl/core/sha1_double_butterfly_hash.sv */
// Top level: sequencer over the chaining and block memories for the 320-bit butterfly hash.
//
//  port group | dir | handshake            | payload
//  req_       | in  | req_valid/req_ready  | kind, data_byte
//  rsp_       | out | rsp_valid/rsp_ready  | digest_word, word_index, last_word
//
// A message byte is accepted, then one block word is read and written back for each of two
// engines; when an engine's block fills, its compression loads the chaining words and the block
// words, runs the SHA-1 rounds, adds, dispatches and writes the chaining words back.
// A finish compresses each engine's padded final block (two blocks for an engine whose last
// block holds 56 bytes or more), runs four second-layer compressions, emits 10 result words,
// then reloads the memories. After reset the same reload runs before the first request is taken.
// A stalled result holds the sequencer; no request is taken until the reload ends.
module sha1_double_butterfly_hash (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  s1dbh_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output s1dbh_pkg::rsp_type  rsp_data
);
   import s1dbh_pkg::*;

   state_type   state_ff, state_in;
   job_type     job_ff, job_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [1:0]  eng_ff, eng_in;
   logic [1:0]  hk_ff, hk_in;
   logic        second_ff, second_in;
   logic        odd_ff, odd_in;
   logic [3:0]  oidx_ff, oidx_in;
   logic [7:0]  byte_ff, byte_in;
   logic [LEN_CNT_BITS-1:0] bcnt_ff [NUM_ENG];
   logic [LEN_CNT_BITS-1:0] bcnt_in [NUM_ENG];
   logic [1:0][4:0][31:0]   lr_ff, lr_in;
   logic [1:0][4:0][31:0]   dw_ff, dw_in;

   logic        c_we, b_we;
   logic [4:0]  c_waddr, c_raddr, c_base;
   logic [5:0]  b_waddr, b_raddr;
   logic [31:0] c_wdata, c_rdata, b_wdata, b_rdata;

   rnd_ctl_type      rnd_ctl;
   logic [31:0]      w_data;
   logic [4:0][31:0] h_out;

   logic [LEN_CNT_BITS-1:0] cur;
   logic [63:0]  cnt64, lenbits;
   logic [5:0]   pos;
   logic [3:0]   jd;
   logic [4:0]   sh;
   logic [31:0]  keep, mark, merged;
   logic [4:0][31:0] src;
   logic [447:0] pad_vec, shifted;
   logic [13:0][31:0] msgw;

   s1dbh_ram #(.WIDTH(32), .DEPTH(CHAIN_DEPTH)) u_chain (
      .clock(clock), .wr_en(c_we), .wr_addr(c_waddr), .wr_data(c_wdata),
      .rd_addr(c_raddr), .rd_data(c_rdata)
   );

   s1dbh_ram #(.WIDTH(32), .DEPTH(BLOCK_DEPTH)) u_block (
      .clock(clock), .wr_en(b_we), .wr_addr(b_waddr), .wr_data(b_wdata),
      .rd_addr(b_raddr), .rd_data(b_rdata)
   );

   s1dbh_round u_round (
      .clock(clock), .ctl(rnd_ctl), .h_data(c_rdata), .w_data(w_data), .h_out(h_out)
   );

   always_comb begin
      cur     = bcnt_ff[eng_ff];
      cnt64   = 64'(cur);
      lenbits = {cnt64[60:0], 3'b000};
      pos     = cur[5:0];
      c_base  = 5'({eng_ff, 2'b00}) + 5'(eng_ff);
      jd      = 4'(cnt_ff - 7'd1);
      sh      = {2'(2'd3 - pos[1:0]), 3'b000};
      keep    = ~(32'hFFFF_FFFF >> {pos[1:0], 3'b000});
      mark    = 32'h8000_0000 >> {pos[1:0], 3'b000};
      merged  = (b_rdata & keep) | mark;
      src     = lr_ff[hk_ff[1]];
      pad_vec = {src[0], src[1], src[2], src[3], src[4], 8'h80, 280'b0};
      shifted = pad_vec >> {3'(3'd4 + 3'(hk_ff)), 3'b000};
      msgw    = shifted;

      case (job_ff)
         JOB_BYTE: w_data = b_rdata;
         JOB_FIN1: begin
            if (jd < pos[5:2]) begin
               w_data = b_rdata;
            end else if (jd == pos[5:2]) begin
               w_data = merged;
            end else if (pos < 6'd56 && jd == 4'd14) begin
               w_data = lenbits[63:32];
            end else if (pos < 6'd56 && jd == 4'd15) begin
               w_data = lenbits[31:0];
            end else begin
               w_data = 32'h0;
            end
         end
         JOB_FIN2: begin
            if (jd == 4'd14) begin
               w_data = lenbits[63:32];
            end else if (jd == 4'd15) begin
               w_data = lenbits[31:0];
            end else begin
               w_data = 32'h0;
            end
         end
         JOB_L2: begin
            if (jd == 4'd15) begin
               w_data = 32'({5'(5'd24 + 5'(hk_ff)), 3'b000});
            end else if (jd == 4'd14) begin
               w_data = 32'h0;
            end else begin
               w_data = msgw[4'(4'd13 - jd)];
            end
         end
         default: w_data = b_rdata;
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      cnt_in    = cnt_ff;
      eng_in    = eng_ff;
      hk_in     = hk_ff;
      second_in = second_ff;
      odd_in    = odd_ff;
      oidx_in   = oidx_ff;
      byte_in   = byte_ff;
      bcnt_in   = bcnt_ff;
      lr_in     = lr_ff;
      dw_in     = dw_ff;
      c_we      = 1'b0;
      c_waddr   = c_base + 5'(cnt_ff[2:0]);
      c_wdata   = h_out[cnt_ff[2:0]];
      c_raddr   = c_base + 5'(cnt_ff[2:0]);
      b_we      = 1'b0;
      b_waddr   = {eng_ff, pos[5:2]};
      b_wdata   = (b_rdata & ~(32'h0000_00FF << sh)) | (32'(byte_ff) << sh);
      b_raddr   = {eng_ff, pos[5:2]};
      rnd_ctl   = '0;
      rnd_ctl.round = cnt_ff;
      rnd_ctl.h_idx = 3'(cnt_ff - 7'd1);
      req_ready = 1'b0;
      rsp_valid = 1'b0;

      case (state_ff)
         ST_INIT: begin
            c_we    = 1'b1;
            c_wdata = sha_iv(cnt_ff[2:0]);
            if (cnt_ff == 7'd0) begin
               b_we    = 1'b1;
               b_waddr = {eng_ff, 4'd0};
               b_wdata = 32'h0;
            end
            for (int k = 0; k < NUM_ENG; k++) begin
               bcnt_in[k] = LEN_CNT_BITS'(k);
            end
            odd_in = 1'b0;
            if (cnt_ff == 7'd4) begin
               cnt_in = 7'd0;
               eng_in = eng_ff + 2'd1;
               if (eng_ff == 2'd3) begin
                  state_in = ST_IDLE;
               end
            end else begin
               cnt_in = cnt_ff + 7'd1;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               byte_in = req_data.data_byte;
               if (req_data.kind == KIND_BYTE) begin
                  eng_in    = odd_ff ? 2'd2 : 2'd0;
                  second_in = 1'b0;
                  odd_in    = ~odd_ff;
                  state_in  = ST_BRD;
               end else begin
                  eng_in   = 2'd0;
                  job_in   = JOB_FIN1;
                  lr_in    = '0;
                  dw_in    = '0;
                  cnt_in   = 7'd0;
                  state_in = ST_HLD;
               end
            end
         end
         ST_BRD: state_in = ST_BWR;
         ST_BWR: begin
            b_we            = 1'b1;
            bcnt_in[eng_ff] = cur + LEN_CNT_BITS'(1);
            if (pos == 6'd63) begin
               job_in   = JOB_BYTE;
               cnt_in   = 7'd0;
               state_in = ST_HLD;
            end else if (!second_ff) begin
               second_in = 1'b1;
               eng_in    = eng_ff + 2'd1;
               state_in  = ST_BRD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_HLD: begin
            rnd_ctl.h_load = (cnt_ff != 7'd0);
            if (cnt_ff == 7'd5) begin
               cnt_in   = 7'd0;
               state_in = ST_WLD;
            end else begin
               cnt_in = cnt_ff + 7'd1;
            end
         end
         ST_WLD: begin
            b_raddr        = {eng_ff, cnt_ff[3:0]};
            rnd_ctl.w_push = (cnt_ff != 7'd0);
            if (cnt_ff == 7'd16) begin
               cnt_in   = 7'd0;
               state_in = ST_RUN;
            end else begin
               cnt_in = cnt_ff + 7'd1;
            end
         end
         ST_RUN: begin
            rnd_ctl.round_en = 1'b1;
            if (cnt_ff == 7'(SHA_ROUNDS - 1)) begin
               state_in = ST_HADD;
            end else begin
               cnt_in = cnt_ff + 7'd1;
            end
         end
         ST_HADD: begin
            rnd_ctl.h_add = 1'b1;
            state_in      = ST_POST;
         end
         ST_POST: begin
            cnt_in = 7'd0;
            case (job_ff)
               JOB_BYTE: state_in = ST_HWB;
               JOB_FIN1, JOB_FIN2: begin
                  if (job_ff == JOB_FIN1 && pos >= 6'd56) begin
                     job_in   = JOB_FIN2;
                     state_in = ST_WLD;
                  end else begin
                     for (int i = 0; i < HALF_WORDS; i++) begin
                        lr_in[eng_ff[0]][i] = lr_ff[eng_ff[0]][i] ^ h_out[i];
                     end
                     if (eng_ff == 2'd3) begin
                        job_in          = JOB_L2;
                        hk_in           = 2'd0;
                        rnd_ctl.iv_load = 1'b1;
                        state_in        = ST_WLD;
                     end else begin
                        eng_in   = eng_ff + 2'd1;
                        job_in   = JOB_FIN1;
                        state_in = ST_HLD;
                     end
                  end
               end
               JOB_L2: begin
                  for (int i = 0; i < HALF_WORDS; i++) begin
                     dw_in[hk_ff[0]][i] = dw_ff[hk_ff[0]][i] ^ h_out[i];
                  end
                  if (hk_ff == 2'd3) begin
                     oidx_in  = 4'd0;
                     state_in = ST_EMIT;
                  end else begin
                     hk_in           = hk_ff + 2'd1;
                     rnd_ctl.iv_load = 1'b1;
                     state_in        = ST_WLD;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_HWB: begin
            c_we = 1'b1;
            if (cnt_ff == 7'd4) begin
               cnt_in = 7'd0;
               if (!second_ff) begin
                  second_in = 1'b1;
                  eng_in    = eng_ff + 2'd1;
                  state_in  = ST_BRD;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               cnt_in = cnt_ff + 7'd1;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (oidx_ff == 4'(DIGEST_WORDS - 1)) begin
                  cnt_in   = 7'd0;
                  eng_in   = 2'd0;
                  state_in = ST_INIT;
               end else begin
                  oidx_in = oidx_ff + 4'd1;
               end
            end
         end
         default: state_in = ST_INIT;
      endcase
   end

   always_comb begin
      if (oidx_ff < 4'(HALF_WORDS)) begin
         rsp_data.digest_word = dw_ff[0][oidx_ff[2:0]];
      end else begin
         rsp_data.digest_word = dw_ff[1][3'(oidx_ff - 4'(HALF_WORDS))];
      end
      rsp_data.word_index = oidx_ff;
      rsp_data.last_word  = (oidx_ff == 4'(DIGEST_WORDS - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_INIT;
         cnt_ff    <= 7'd0;
         eng_ff    <= 2'd0;
         second_ff <= 1'b0;
         odd_ff    <= 1'b0;
         oidx_ff   <= 4'd0;
         job_ff    <= JOB_BYTE;
         hk_ff     <= 2'd0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         eng_ff    <= eng_in;
         second_ff <= second_in;
         odd_ff    <= odd_in;
         oidx_ff   <= oidx_in;
         job_ff    <= job_in;
         hk_ff     <= hk_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      bcnt_ff <= bcnt_in;
      lr_ff   <= lr_in;
      dw_ff   <= dw_in;
   end
endmodule

/* rtl/core/s1dbh_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module s1dbh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/core/s1dbh_round.sv */
// SHA-1 compression unit: chaining registers, message schedule window and one round per cycle while round_en is set.
module s1dbh_round (
   input  logic                     clock,
   input  s1dbh_pkg::rnd_ctl_type   ctl,
   input  logic [31:0]              h_data,
   input  logic [31:0]              w_data,
   output logic [4:0][31:0]         h_out
);
   import s1dbh_pkg::*;

   logic [4:0][31:0]  h_ff, h_in;
   logic [4:0][31:0]  v_ff, v_in;
   logic [15:0][31:0] w_ff, w_in;
   logic [4:0][31:0]  src;
   logic [31:0]       f_val, k_val, tmp, w_new, x;

   always_comb begin
      src   = (ctl.round == 7'd0) ? h_ff : v_ff;
      if (ctl.round < 7'd20) begin
         f_val = (src[1] & src[2]) | (~src[1] & src[3]);
         k_val = 32'h5A82_7999;
      end else if (ctl.round < 7'd40) begin
         f_val = src[1] ^ src[2] ^ src[3];
         k_val = 32'h6ED9_EBA1;
      end else if (ctl.round < 7'd60) begin
         f_val = (src[1] & src[2]) | (src[1] & src[3]) | (src[2] & src[3]);
         k_val = 32'h8F1B_BCDC;
      end else begin
         f_val = src[1] ^ src[2] ^ src[3];
         k_val = 32'hCA62_C1D6;
      end
      tmp   = {src[0][26:0], src[0][31:27]} + f_val + src[4] + k_val + w_ff[0];
      x     = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];
      w_new = {x[30:0], x[31]};

      h_in = h_ff;
      if (ctl.iv_load) begin
         for (int i = 0; i < HALF_WORDS; i++) begin
            h_in[i] = sha_iv(3'(i));
         end
      end
      if (ctl.h_load) begin
         h_in[ctl.h_idx] = h_data;
      end
      if (ctl.h_add) begin
         for (int i = 0; i < HALF_WORDS; i++) begin
            h_in[i] = h_ff[i] + v_ff[i];
         end
      end

      w_in = w_ff;
      if (ctl.w_push) begin
         w_in = {w_data, w_ff[15:1]};
      end else if (ctl.round_en) begin
         w_in = {w_new, w_ff[15:1]};
      end

      v_in = v_ff;
      if (ctl.round_en) begin
         v_in[0] = tmp;
         v_in[1] = src[0];
         v_in[2] = {src[1][1:0], src[1][31:2]};
         v_in[3] = src[2];
         v_in[4] = src[3];
      end
   end

   always_ff @(posedge clock) begin
      h_ff <= h_in;
      v_ff <= v_in;
      w_ff <= w_in;
   end

   assign h_out = h_ff;
endmodule

/* dv/sha1_double_butterfly_hash_checker.sv */
// Checker that predicts the 320-bit butterfly digest and compares each response word.
`timescale 1ns / 1ps

module sha1_double_butterfly_hash_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  s1dbh_pkg::req_type  req_data,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  s1dbh_pkg::rsp_type  rsp_data,
   output int                  fail_count,
   output int                  pending_words
);
   import s1dbh_pkg::*;

   logic [31:0] chain [NUM_ENG][HALF_WORDS];
   logic [31:0] blk   [NUM_ENG][BLOCK_WORDS];
   logic [63:0] count [NUM_ENG];
   logic        odd_pos;
   rsp_type     digest_q [$];

   function automatic logic [31:0] rol(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   task automatic sha_compress(inout logic [31:0] h [HALF_WORDS],
                               input logic [31:0] b [BLOCK_WORDS]);
      logic [31:0] w [80];
      logic [31:0] a, bb, c, d, e, f, k, t;
      for (int i = 0; i < 16; i++) w[i] = b[i];
      for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
      a = h[0]; bb = h[1]; c = h[2]; d = h[3]; e = h[4];
      for (int i = 0; i < 80; i++) begin
         if (i < 20) begin
            f = (bb & c) | (~bb & d); k = 32'h5A827999;
         end else if (i < 40) begin
            f = bb ^ c ^ d; k = 32'h6ED9EBA1;
         end else if (i < 60) begin
            f = (bb & c) | (bb & d) | (c & d); k = 32'h8F1BBCDC;
         end else begin
            f = bb ^ c ^ d; k = 32'hCA62C1D6;
         end
         t = rol(a, 5) + f + e + k + w[i];
         e = d; d = c; c = rol(bb, 30); bb = a; a = t;
      end
      h[0] += a; h[1] += bb; h[2] += c; h[3] += d; h[4] += e;
   endtask

   task automatic absorb(inout logic [31:0] h [HALF_WORDS], inout logic [31:0] b [BLOCK_WORDS],
                         inout logic [63:0] cnt, input logic [7:0] v);
      int p;
      p = int'(cnt[5:0]);
      b[p/4][(3 - p%4)*8 +: 8] = v;
      cnt = cnt + 64'd1;
      if (p == 63) sha_compress(h, b);
   endtask

   task automatic finalize(input logic [31:0] h_in [HALF_WORDS],
                           input logic [31:0] b_in [BLOCK_WORDS],
                           input logic [63:0] cnt, output logic [31:0] out [HALF_WORDS]);
      logic [31:0] h [HALF_WORDS];
      logic [31:0] b [BLOCK_WORDS];
      logic [63:0] bits;
      int p;
      h = h_in; b = b_in; bits = cnt << 3; p = int'(cnt[5:0]);
      b[p/4][(3 - p%4)*8 +: 8] = 8'h80;
      p++;
      if (p > 56) begin
         while (p < 64) begin
            b[p/4][(3 - p%4)*8 +: 8] = 8'h00; p++;
         end
         sha_compress(h, b);
         p = 0;
      end
      while (p < 56) begin
         b[p/4][(3 - p%4)*8 +: 8] = 8'h00; p++;
      end
      b[14] = bits[63:32];
      b[15] = bits[31:0];
      sha_compress(h, b);
      out = h;
   endtask

   task automatic start_engine(output logic [31:0] h [HALF_WORDS],
                               output logic [31:0] b [BLOCK_WORDS],
                               output logic [63:0] cnt, input int zeros);
      for (int i = 0; i < HALF_WORDS; i++) h[i] = sha_iv(3'(i));
      for (int i = 0; i < BLOCK_WORDS; i++) b[i] = '0;
      cnt = '0;
      for (int i = 0; i < zeros; i++) absorb(h, b, cnt, 8'h00);
   endtask

   task automatic keyed_hash(input int zeros, input logic [31:0] msg [HALF_WORDS],
                             output logic [31:0] out [HALF_WORDS]);
      logic [31:0] h [HALF_WORDS];
      logic [31:0] b [BLOCK_WORDS];
      logic [63:0] cnt;
      start_engine(h, b, cnt, zeros);
      for (int i = 0; i < 20; i++) absorb(h, b, cnt, msg[i/4][(3 - i%4)*8 +: 8]);
      finalize(h, b, cnt, out);
   endtask

   task automatic restart_all();
      for (int k = 0; k < NUM_ENG; k++) start_engine(chain[k], blk[k], count[k], k);
      odd_pos = 1'b0;
   endtask

   task automatic predict_request(input req_type r);
      logic [31:0] fin [NUM_ENG][HALF_WORDS];
      logic [31:0] lft [HALF_WORDS], rgt [HALF_WORDS];
      logic [31:0] h4 [HALF_WORDS], h5 [HALF_WORDS], h6 [HALF_WORDS], h7 [HALF_WORDS];
      rsp_type w;
      int base;
      if (r.kind == KIND_BYTE) begin
         base = odd_pos ? 2 : 0;
         for (int k = base; k < base + 2; k++) absorb(chain[k], blk[k], count[k], r.data_byte);
         odd_pos = ~odd_pos;
      end else begin
         for (int k = 0; k < NUM_ENG; k++) finalize(chain[k], blk[k], count[k], fin[k]);
         for (int j = 0; j < HALF_WORDS; j++) begin
            lft[j] = fin[0][j] ^ fin[2][j];
            rgt[j] = fin[1][j] ^ fin[3][j];
         end
         keyed_hash(4, lft, h4);
         keyed_hash(5, lft, h5);
         keyed_hash(6, rgt, h6);
         keyed_hash(7, rgt, h7);
         for (int j = 0; j < DIGEST_WORDS; j++) begin
            w.digest_word = (j < HALF_WORDS) ? h4[j] ^ h6[j]
                                             : h5[j-HALF_WORDS] ^ h7[j-HALF_WORDS];
            w.word_index  = 4'(j);
            w.last_word   = (j == DIGEST_WORDS - 1);
            digest_q.push_back(w);
         end
         restart_all();
      end
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         fail_count = 0;
         digest_q.delete();
         restart_all();
      end else begin
         if (req_valid && req_ready) predict_request(req_data);
         if (rsp_valid && rsp_ready) begin
            if (digest_q.size() == 0) begin
               $error("unexpected response word %h", rsp_data);
               fail_count++;
            end else begin
               e = digest_q.pop_front();
               if (e.digest_word !== rsp_data.digest_word) begin
                  $error("digest_word expected %h actual %h", e.digest_word, rsp_data.digest_word);
                  fail_count++;
               end
               if (e.word_index !== rsp_data.word_index) begin
                  $error("word_index expected %0d actual %0d", e.word_index, rsp_data.word_index);
                  fail_count++;
               end
               if (e.last_word !== rsp_data.last_word) begin
                  $error("last_word expected %0d actual %0d", e.last_word, rsp_data.last_word);
                  fail_count++;
               end
            end
         end
      end
      pending_words = digest_q.size();
   end
endmodule

/* dv/sha1_double_butterfly_hash_tb.sv */
// Testbench top: drives message bytes and finish requests and reports the verdict.
`timescale 1ns / 1ps

module sha1_double_butterfly_hash_tb;
   import s1dbh_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_words;
   int      send_idle_pct;
   int      recv_idle_pct;

   sha1_double_butterfly_hash u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   sha1_double_butterfly_hash_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_words(pending_words)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_request(input logic kind, input logic [7:0] value);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{kind: kind, data_byte: value};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_message(input int len);
      for (int i = 0; i < len; i++) send_request(KIND_BYTE, 8'($urandom_range(255)));
      send_request(KIND_FINISH, 8'($urandom_range(255)));
   endtask

   initial begin
      int lens [3];
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      send_idle_pct = 18;
      recv_idle_pct = 79;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // Empty message, data ignored on finish, and byte field extremes.
      send_request(KIND_FINISH, 8'hFF);
      send_request(KIND_BYTE, 8'h00);
      send_request(KIND_BYTE, 8'hFF);
      send_request(KIND_FINISH, 8'h00);
      send_request(KIND_BYTE, 8'hA5);
      send_request(KIND_FINISH, 8'h5A);
      lens = '{80, 85, 85};
      for (int p = 0; p < 3; p++) begin
         if (p == 1) begin
            send_idle_pct = 79; recv_idle_pct = 18;
         end else if (p == 2) begin
            send_idle_pct = 0; recv_idle_pct = 0;
         end
         for (int n = 0; n < lens[p]; ) begin
            int len;
            len = ($urandom_range(9) == 0) ? $urandom_range(110, 130) : $urandom_range(0, 8);
            send_message(len);
            n += len + 1;
         end
      end
      req_valid <= 1'b0;
      while (pending_words != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #200ms;
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule

/* filelist.f */
rtl/core/s1dbh_pkg.sv
rtl/core/s1dbh_ram.sv
rtl/core/s1dbh_round.sv
rtl/core/sha1_double_butterfly_hash.sv
dv/sha1_double_butterfly_hash_checker.sv
dv/sha1_double_butterfly_hash_tb.sv
